@@ rtl/core/multi_axis_step_scheduler_assert.svh @@
// assertion macros for the port-level checker file
`ifndef MULTI_AXIS_STEP_SCHEDULER_ASSERT_SVH
`define MULTI_AXIS_STEP_SCHEDULER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MASS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define MASS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ rtl/core/mass_pkg.sv @@
// shared types and constants of the step scheduler
`timescale 1ns / 1ps
package mass_pkg;
	localparam int CHANNELS = 7;
	localparam int ENDSTOPS = 12;
	localparam int POS_WIDTH = 32;
	localparam int CH_W = 3;
	localparam int ES_IDX_W = 4;
	localparam int MAP_W = 4 * CHANNELS;
	localparam int CNT_W = 34;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] MODE_HMIN = 2'd1;
	localparam logic [1:0] MODE_HMAX = 2'd2;

	localparam logic [2:0] CFG_THRESH = 3'd0;
	localparam logic [2:0] CFG_MAXINT = 3'd1;
	localparam logic [2:0] CFG_ENMASK = 3'd2;
	localparam logic [2:0] CFG_IDLE = 3'd3;
	localparam logic [2:0] CFG_MINMAP = 3'd4;
	localparam logic [2:0] CFG_MAXMAP = 3'd5;

	// commands from the controller to the datapath
	typedef struct packed {
		logic decode;     // first cycle of every request, clears the pulses
		logic start;      // load a channel from the captured request
		logic clear_evt;
		logic tick_clr;   // clear phase-one step flags and preset the smallest count
		logic ph1;        // direction and countdown for cur channel
		logic ph2;        // step for cur channel
		logic ph3;        // sample endstops
		logic ph4;        // stop checks and rearm for cur channel
		logic ph5;        // commit interval
		logic [CH_W-1:0] cur;
	} mass_cmd_t;

	typedef struct packed {
		logic any_active;
	} mass_sts_t;
endpackage

@@ rtl/core/multi_axis_step_scheduler.sv @@
// Sequence: a start, clear, idle tick or other request is decoded and then its result is
// loaded; a tick with an active channel runs decode, two seven-channel walks, sample, a
// third walk, commit and result load.
// Throughput: one request at a time; the input stalls until the result transaction is taken.
// Reset: arst_n clears all channels, positions and flags; interval reads max.
// Configuration writes are taken at any cycle the write enable is high.
`timescale 1ns / 1ps
module multi_axis_step_scheduler (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [27:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] req_type,
	input  logic [2:0] channel_index,
	input  logic signed [31:0] target_steps,
	input  logic [23:0] step_period,
	input  logic [1:0] move_mode,
	input  logic [11:0] endstop_levels,
	output logic out_valid,
	input  logic out_stall,
	output logic [6:0] step_pulses,
	output logic [6:0] direction_bits,
	output logic [6:0] active_channels,
	output logic [15:0] next_interval,
	output logic [11:0] endstop_hits,
	output logic endstop_event,
	output logic signed [31:0] channel_position
);
	import mass_pkg::*;

	mass_cmd_t cmd;
	mass_sts_t sts;
	logic busy, done, in_fire;
	logic [2:0] ch_q;
	logic signed [31:0] tgt_q;
	logic [23:0] per_q;
	logic [1:0] mode_q;
	logic [11:0] lev_q;
	logic [6:0] pul, dir, act;
	logic [15:0] itv;
	logic [11:0] hit;
	logic evt;
	logic signed [31:0] pos;
	logic load_q;

	assign in_stall = busy || load_q || out_valid;
	assign in_fire = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q <= channel_index;
			tgt_q <= target_steps;
			per_q <= step_period;
			mode_q <= move_mode;
			lev_q <= endstop_levels;
		end
	end

	mass_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .req(req_type),
		.sts(sts), .cmd(cmd), .busy(busy), .done(done)
	);

	mass_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_idx(cfg_index), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req_ch(ch_q), .req_target(tgt_q), .req_period(per_q), .req_mode(mode_q),
		.req_levels(lev_q), .pulses(pul), .dirs(dir), .act(act), .interval(itv),
		.hits(hit), .evt(evt), .pos_out(pos)
	);

	// result register, loaded in the cycle after the last phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			load_q <= done;
			if (load_q) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_q) begin
			step_pulses <= pul;
			direction_bits <= dir;
			active_channels <= act;
			next_interval <= itv;
			endstop_hits <= hit;
			endstop_event <= evt;
			channel_position <= pos;
		end
	end
endmodule

@@ rtl/core/mass_ctrl.sv @@
// controller sequencing the phases of one request
`timescale 1ns / 1ps
module mass_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic [1:0] req,
	input  mass_pkg::mass_sts_t sts,
	output mass_pkg::mass_cmd_t cmd,
	output logic busy,
	output logic done
);
	import mass_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DECODE, S_P1, S_P2, S_P3, S_P4, S_P5} state_t;

	state_t state_q;
	logic [CH_W-1:0] cur_q;
	logic [1:0] req_q;
	logic last;

	assign last = (cur_q == CH_W'(CHANNELS - 1));
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.cur = cur_q;
		done = 1'b0;
		case (state_q)
			S_DECODE: begin
				done = 1'b1;
				cmd.decode = 1'b1;
				if (req_q == REQ_START) cmd.start = 1'b1;
				else if (req_q == REQ_CLEAR) cmd.clear_evt = 1'b1;
				else if (req_q == REQ_TICK && sts.any_active) begin
					cmd.tick_clr = 1'b1;
					done = 1'b0;
				end
			end
			S_P1: cmd.ph1 = 1'b1;
			S_P2: cmd.ph2 = 1'b1;
			S_P3: cmd.ph3 = 1'b1;
			S_P4: cmd.ph4 = 1'b1;
			S_P5: begin
				cmd.ph5 = 1'b1;
				done = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= '0;
			req_q <= REQ_TICK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						req_q <= req;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					cur_q <= '0;
					if (cmd.tick_clr) state_q <= S_P1;
					else state_q <= S_IDLE;
				end
				S_P1: begin
					cur_q <= last ? '0 : cur_q + 1'b1;
					if (last) state_q <= S_P2;
				end
				S_P2: begin
					cur_q <= last ? '0 : cur_q + 1'b1;
					if (last) state_q <= S_P3;
				end
				S_P3: state_q <= S_P4;
				S_P4: begin
					cur_q <= last ? '0 : cur_q + 1'b1;
					if (last) state_q <= S_P5;
				end
				S_P5: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/mass_dp.sv @@
// per-channel state and arithmetic, one channel per cycle
`timescale 1ns / 1ps
module mass_dp (
	input  logic clk,
	input  logic arst_n,
	input  mass_pkg::mass_cmd_t cmd,
	output mass_pkg::mass_sts_t sts,
	input  logic [2:0] cfg_idx,
	input  logic cfg_we,
	input  logic [27:0] cfg_data,
	input  logic [2:0] req_ch,
	input  logic signed [31:0] req_target,
	input  logic [23:0] req_period,
	input  logic [1:0] req_mode,
	input  logic [11:0] req_levels,
	output logic [6:0] pulses,
	output logic [6:0] dirs,
	output logic [6:0] act,
	output logic [15:0] interval,
	output logic [11:0] hits,
	output logic evt,
	output logic signed [31:0] pos_out
);
	import mass_pkg::*;

	logic [15:0] thresh_q, maxint_q;
	logic [ENDSTOPS-1:0] enmask_q;
	logic idle_q;
	logic [MAP_W-1:0] minmap_q, maxmap_q;

	logic signed [POS_WIDTH-1:0] pos_q [CHANNELS];
	logic signed [POS_WIDTH-1:0] tgt_q [CHANNELS];
	logic signed [CNT_W-1:0] cnt_q [CHANNELS];
	logic signed [CNT_W-1:0] carry_q [CHANNELS];
	logic [23:0] per_q [CHANNELS];
	logic [CHANNELS-1:0] act_q, hmin_q, hmax_q, up_q, arm_q, step_q, pul_q;
	logic [ENDSTOPS-1:0] stat_q;
	logic evt_q;
	logic [15:0] int_q;
	logic signed [CNT_W-1:0] small_q;

	logic [CH_W-1:0] c;
	logic [ES_IDX_W-1:0] mni, mxi;
	logic mn, mx, tp, tq, tl;
	logic signed [CNT_W-1:0] cdec, rearm;
	logic [ENDSTOPS-1:0] newstat;

	assign c = cmd.cur;
	assign mni = minmap_q[ES_IDX_W*c +: ES_IDX_W];
	assign mxi = maxmap_q[ES_IDX_W*c +: ES_IDX_W];
	assign mn = (32'(mni) < ENDSTOPS) && stat_q[mni[$clog2(ENDSTOPS)-1:0]];
	assign mx = (32'(mxi) < ENDSTOPS) && stat_q[mxi[$clog2(ENDSTOPS)-1:0]];
	assign tp = tgt_q[c] > pos_q[c];
	assign tq = tgt_q[c] == pos_q[c];
	assign tl = tgt_q[c] < pos_q[c];
	assign cdec = cnt_q[c] - CNT_W'(int_q);
	assign rearm = CNT_W'(per_q[c]) + ((carry_q[c] > 0) ? carry_q[c] : '0);
	// a switch is hit when it is enabled and its raw level differs from the idle level
	assign newstat = enmask_q & (req_levels ^ {ENDSTOPS{idle_q}});
	assign sts.any_active = |act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
			maxint_q <= 16'hFFFF;
			enmask_q <= '1;
			idle_q <= 1'b0;
			minmap_q <= '1;
			maxmap_q <= '1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_THRESH: thresh_q <= cfg_data[15:0];
				CFG_MAXINT: maxint_q <= cfg_data[15:0];
				CFG_ENMASK: enmask_q <= cfg_data[ENDSTOPS-1:0];
				CFG_IDLE:   idle_q <= cfg_data[0];
				CFG_MINMAP: minmap_q <= cfg_data[MAP_W-1:0];
				CFG_MAXMAP: maxmap_q <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i] <= '0;
				tgt_q[i] <= '0;
				cnt_q[i] <= '0;
				carry_q[i] <= '0;
				per_q[i] <= '0;
			end
			act_q <= '0; hmin_q <= '0; hmax_q <= '0; up_q <= '0; arm_q <= '0;
			step_q <= '0; pul_q <= '0;
			stat_q <= '0;
			evt_q <= 1'b0;
			int_q <= 16'hFFFF;
			small_q <= '0;
		end else begin
			if (cmd.decode) pul_q <= '0;
			if (cmd.start) begin
				if (32'(req_ch) < CHANNELS) begin
					tgt_q[req_ch[CH_W-1:0]] <= req_target;
					per_q[req_ch[CH_W-1:0]] <= req_period;
					cnt_q[req_ch[CH_W-1:0]] <= '0;
					carry_q[req_ch[CH_W-1:0]] <= '0;
					act_q[req_ch[CH_W-1:0]] <= 1'b1;
					arm_q[req_ch[CH_W-1:0]] <= 1'b0;
					hmin_q[req_ch[CH_W-1:0]] <= (req_mode == MODE_HMIN);
					hmax_q[req_ch[CH_W-1:0]] <= (req_mode == MODE_HMAX);
				end
			end
			if (cmd.clear_evt) begin
				evt_q <= 1'b0;
			end
			if (cmd.tick_clr) begin
				step_q <= '0;
				small_q <= CNT_W'(maxint_q);
			end
			if (cmd.ph1) begin
				if (!act_q[c]) begin
					carry_q[c] <= '0;
					arm_q[c] <= 1'b0;
				end else begin
					if ((!tp || hmin_q[c]) && !hmax_q[c]) up_q[c] <= 1'b0;
					if ((tp || hmax_q[c]) && !hmin_q[c]) up_q[c] <= 1'b1;
					if (arm_q[c]) begin
						if (cdec <= $signed(CNT_W'(thresh_q))) begin
							step_q[c] <= 1'b1;
							carry_q[c] <= cdec;
							arm_q[c] <= 1'b0;
							cnt_q[c] <= '0;
						end else begin
							cnt_q[c] <= cdec;
							carry_q[c] <= '0;
						end
					end
				end
			end
			if (cmd.ph2 && step_q[c]) begin
				if (up_q[c]) begin
					if (!mx) begin
						pos_q[c] <= pos_q[c] + 1'b1;
						pul_q[c] <= 1'b1;
					end
				end else if (!mn) begin
					pos_q[c] <= pos_q[c] - 1'b1;
					pul_q[c] <= 1'b1;
				end
			end
			if (cmd.ph3) begin
				if (|(newstat & ~stat_q)) evt_q <= 1'b1;
				stat_q <= newstat;
			end
			if (cmd.ph4) begin : p4
				logic a;
				a = act_q[c];
				if (hmin_q[c] || hmax_q[c]) begin
					if (hmax_q[c] && mx) begin
						hmax_q[c] <= 1'b0; a = 1'b0; tgt_q[c] <= pos_q[c];
					end
					if (hmin_q[c] && mn) begin
						hmin_q[c] <= 1'b0; a = 1'b0; tgt_q[c] <= pos_q[c];
					end
				end else if (tq) begin
					a = 1'b0;
				end else if ((tp && mx) || (tl && mn)) begin
					tgt_q[c] <= pos_q[c]; a = 1'b0;
				end
				act_q[c] <= a;
				if (a && !arm_q[c]) begin
					cnt_q[c] <= rearm;
					arm_q[c] <= 1'b1;
					if (carry_q[c] > 0) carry_q[c] <= '0;
					if (rearm <= small_q) small_q <= rearm;
				end else if (a && cnt_q[c] <= small_q) begin
					small_q <= cnt_q[c];
				end
			end
			if (cmd.ph5) begin
				if (small_q > CNT_W'(maxint_q)) int_q <= maxint_q;
				else if (small_q < 0) int_q <= '0;
				else int_q <= small_q[15:0];
			end
		end
	end

	assign pulses = pul_q;
	assign dirs = up_q;
	assign act = act_q;
	assign interval = int_q;
	assign hits = stat_q;
	assign evt = evt_q;
	assign pos_out = (32'(req_ch) < CHANNELS) ? pos_q[req_ch[CH_W-1:0]] : '0;
endmodule

@@ rtl/core/mass_checker.sv @@
// port-level checker for the step scheduler, bound to the top level
`timescale 1ns / 1ps
`include "multi_axis_step_scheduler_assert.svh"
module mass_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [6:0] step_pulses,
	input logic signed [31:0] channel_position
);
	`MASS_ASSERT_NEXT(a_accept_stalls, clk, arst_n, in_valid && !in_stall, in_stall)
	`MASS_ASSERT_IMPL(a_result_blocks, clk, arst_n, out_valid, in_stall)
	`MASS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(channel_position))
	`MASS_ASSERT_NEXT(a_pulse_range, clk, arst_n, out_valid && !out_stall,
		!out_valid || (step_pulses & ~7'h7f) == 7'd0)
endmodule

bind multi_axis_step_scheduler mass_checker u_mass_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.step_pulses(step_pulses), .channel_position(channel_position)
);

@@ dv/tb_multi_axis_step_scheduler.sv @@
// self-checking testbench for the multi-axis step scheduler
`timescale 1ns / 1ps
module tb_multi_axis_step_scheduler;
	import mass_pkg::*;

	localparam logic [1:0] REQ_NOP = 2'd3;
	localparam logic [1:0] MODE_MOVE = 2'd0;
	localparam logic [1:0] MODE_ODD = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [1:0] req;
		logic [2:0] ch;
		logic signed [31:0] tgt;
		logic [23:0] per;
		logic [1:0] mode;
		logic [11:0] lv;
	} sched_req_t;

	typedef struct {
		logic [6:0] pulses;
		logic [6:0] dirs;
		logic [6:0] act;
		logic [15:0] ival;
		logic [11:0] hits;
		logic evt;
		logic signed [31:0] pos;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = CFG_THRESH;
	logic [27:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = REQ_TICK;
	logic [2:0] channel_index = '0;
	logic signed [31:0] target_steps = '0;
	logic [23:0] step_period = '0;
	logic [1:0] move_mode = MODE_MOVE;
	logic [11:0] endstop_levels = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [6:0] step_pulses;
	logic [6:0] direction_bits;
	logic [6:0] active_channels;
	logic [15:0] next_interval;
	logic [11:0] endstop_hits;
	logic endstop_event;
	logic signed [31:0] channel_position;

	multi_axis_step_scheduler DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [15:0] thr_cfg = 16'd0;
	logic [15:0] maxint_cfg = 16'hFFFF;
	logic [11:0] enmask_cfg = 12'hFFF;
	logic idle_cfg = 1'b0;
	logic [27:0] minmap_cfg = 28'hFFFFFFF;
	logic [27:0] maxmap_cfg = 28'hFFFFFFF;
	logic signed [31:0] pos_q [CHANNELS];
	logic signed [31:0] tgt_q [CHANNELS];
	longint cnt_q [CHANNELS];
	longint carry_q [CHANNELS];
	logic [23:0] per_q [CHANNELS];
	logic [CHANNELS-1:0] act_q = '0, hmin_q = '0, hmax_q = '0, up_q = '0, armed_q = '0;
	logic [11:0] es_q = '0;
	logic evt_q = 1'b0;
	logic [15:0] ival_q = 16'hFFFF;

	sched_req_t pending [$];
	sched_res_t expected [$];
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;

	initial begin
		for (int i = 0; i < CHANNELS; i++) begin
			pos_q[i] = 0; tgt_q[i] = 0; cnt_q[i] = 0; carry_q[i] = 0; per_q[i] = 0;
		end
	end

	function automatic bit switch_hit(input logic [27:0] map, input int ch);
		logic [3:0] idx;
		idx = map[4*ch +: 4];
		if (idx >= ENDSTOPS)
			return 1'b0;
		return es_q[idx];
	endfunction

	function automatic sched_res_t schedule_request(input sched_req_t r);
		sched_res_t res;
		bit tp, mn, mx;
		logic [CHANNELS-1:0] fire;
		logic [11:0] ns;
		longint smallest;
		res.pulses = '0;
		fire = '0;
		if (r.req == REQ_TICK && act_q != '0) begin
			// direction and countdown
			for (int i = 0; i < CHANNELS; i++) begin
				if (!act_q[i]) begin
					carry_q[i] = 0;
					armed_q[i] = 1'b0;
					continue;
				end
				tp = tgt_q[i] > pos_q[i];
				if ((!tp || hmin_q[i]) && !hmax_q[i]) up_q[i] = 1'b0;
				if ((tp || hmax_q[i]) && !hmin_q[i]) up_q[i] = 1'b1;
				if (armed_q[i]) begin
					cnt_q[i] -= longint'(ival_q);
					if (cnt_q[i] <= longint'(thr_cfg)) begin
						fire[i] = 1'b1;
						carry_q[i] = cnt_q[i];
						armed_q[i] = 1'b0;
						cnt_q[i] = 0;
					end else
						carry_q[i] = 0;
				end
			end
			// steps, blocked by the switch seen at the previous sample
			for (int i = 0; i < CHANNELS; i++) begin
				if (!fire[i]) continue;
				if (up_q[i]) begin
					if (!switch_hit(maxmap_cfg, i)) begin
						pos_q[i] = pos_q[i] + 1;
						res.pulses[i] = 1'b1;
					end
				end else if (!switch_hit(minmap_cfg, i)) begin
					pos_q[i] = pos_q[i] - 1;
					res.pulses[i] = 1'b1;
				end
			end
			ns = enmask_cfg & (r.lv ^ {12{idle_cfg}});
			if ((ns & ~es_q) != '0) evt_q = 1'b1;
			es_q = ns;
			// stop checks run on every channel
			for (int i = 0; i < CHANNELS; i++) begin
				mn = switch_hit(minmap_cfg, i);
				mx = switch_hit(maxmap_cfg, i);
				if (hmin_q[i] || hmax_q[i]) begin
					if (hmax_q[i] && mx) begin
						hmax_q[i] = 1'b0; act_q[i] = 1'b0; tgt_q[i] = pos_q[i];
					end
					if (hmin_q[i] && mn) begin
						hmin_q[i] = 1'b0; act_q[i] = 1'b0; tgt_q[i] = pos_q[i];
					end
				end else if (tgt_q[i] == pos_q[i])
					act_q[i] = 1'b0;
				else begin
					if (tgt_q[i] > pos_q[i] && mx) begin
						tgt_q[i] = pos_q[i]; act_q[i] = 1'b0;
					end
					if (tgt_q[i] < pos_q[i] && mn) begin
						tgt_q[i] = pos_q[i]; act_q[i] = 1'b0;
					end
				end
			end
			// rearm and pick the next interval
			smallest = longint'(maxint_cfg);
			for (int i = 0; i < CHANNELS; i++) begin
				if (act_q[i] && !armed_q[i]) begin
					cnt_q[i] = longint'(per_q[i]);
					armed_q[i] = 1'b1;
					if (carry_q[i] > 0) begin
						cnt_q[i] += carry_q[i];
						carry_q[i] = 0;
					end
				end
				if (act_q[i] && armed_q[i] && cnt_q[i] <= smallest)
					smallest = cnt_q[i];
			end
			if (smallest > longint'(maxint_cfg)) smallest = longint'(maxint_cfg);
			if (smallest < 0) smallest = 0;
			ival_q = smallest[15:0];
		end else if (r.req == REQ_START && r.ch < CHANNELS) begin
			tgt_q[r.ch] = r.tgt;
			per_q[r.ch] = r.per;
			cnt_q[r.ch] = 0;
			carry_q[r.ch] = 0;
			act_q[r.ch] = 1'b1;
			armed_q[r.ch] = 1'b0;
			hmin_q[r.ch] = (r.mode == MODE_HMIN);
			hmax_q[r.ch] = (r.mode == MODE_HMAX);
		end else if (r.req == REQ_CLEAR)
			evt_q = 1'b0;
		res.dirs = up_q;
		res.act = act_q;
		res.ival = ival_q;
		res.hits = es_q;
		res.evt = evt_q;
		res.pos = (r.ch < CHANNELS) ? pos_q[r.ch] : '0;
		return res;
	endfunction

	// driver: bursts of transactions separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		sched_req_t it;
		bit taken;
		if (arst_n) begin
			taken = in_valid && !in_stall;
			if (taken) begin
				it.req = req_type; it.ch = channel_index; it.tgt = target_steps;
				it.per = step_period; it.mode = move_mode; it.lv = endstop_levels;
				expected.push_back(schedule_request(it));
			end
			if (!(in_valid && !taken)) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				end
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					it = pending.pop_front();
					burst_left--;
					in_valid <= 1'b1;
					req_type <= it.req;
					channel_index <= it.ch;
					target_steps <= it.tgt;
					step_period <= it.per;
					move_mode <= it.mode;
					endstop_levels <= it.lv;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result transaction, stall on its own pattern
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stall_pct = 0;
	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					e = expected.pop_front();
					if (step_pulses !== e.pulses) begin
						$error("step_pulses exp %h got %h", e.pulses, step_pulses); errors++;
					end
					if (direction_bits !== e.dirs) begin
						$error("direction_bits exp %h got %h", e.dirs, direction_bits); errors++;
					end
					if (active_channels !== e.act) begin
						$error("active_channels exp %h got %h", e.act, active_channels); errors++;
					end
					if (next_interval !== e.ival) begin
						$error("next_interval exp %0d got %0d", e.ival, next_interval); errors++;
					end
					if (endstop_hits !== e.hits) begin
						$error("endstop_hits exp %h got %h", e.hits, endstop_hits); errors++;
					end
					if (endstop_event !== e.evt) begin
						$error("endstop_event exp %b got %b", e.evt, endstop_event); errors++;
					end
					if (channel_position !== e.pos) begin
						$error("channel_position exp %0d got %0d", e.pos, channel_position);
						errors++;
					end
				end
				if (results_seen % 50 == 0)
					stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
			end
			// one long hold-off so the block backs up into its input
			if (!hold_done && results_seen == 150) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [27:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_THRESH: thr_cfg = val[15:0];
			CFG_MAXINT: maxint_cfg = val[15:0];
			CFG_ENMASK: enmask_cfg = val[11:0];
			CFG_IDLE: idle_cfg = val[0];
			CFG_MINMAP: minmap_cfg = val;
			CFG_MAXMAP: maxmap_cfg = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_req(input logic [1:0] req, input logic [2:0] ch,
			input logic signed [31:0] tgt, input logic [23:0] per,
			input logic [1:0] mode, input logic [11:0] lv);
		sched_req_t it;
		it.req = req; it.ch = ch; it.tgt = tgt; it.per = per; it.mode = mode; it.lv = lv;
		pending.push_back(it);
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_random(input int n);
		logic [1:0] req, mode;
		logic [2:0] ch;
		logic signed [31:0] tgt;
		logic [23:0] per;
		logic [11:0] lv;
		int k;
		for (int j = 0; j < n; j++) begin
			k = $urandom_range(0, 99);
			req = (k < 60) ? REQ_TICK : (k < 88) ? REQ_START : (k < 96) ? REQ_CLEAR : REQ_NOP;
			ch = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
			tgt = ($urandom_range(0, 15) == 0) ? $signed($urandom) :
				$signed(32'($urandom_range(0, 60)) - 32'sd30);
			k = $urandom_range(0, 19);
			per = (k == 0) ? 24'($urandom) : (k == 1) ? 24'hFFFFFF : 24'($urandom_range(0, 300));
			mode = ($urandom_range(0, 1) == 0) ? MODE_MOVE : 2'($urandom_range(0, 3));
			lv = idle_cfg ? 12'hFFF : 12'h000;
			if ($urandom_range(0, 3) == 0) lv ^= 12'(1) << $urandom_range(0, 11);
			if ($urandom_range(0, 19) == 0) lv = 12'($urandom);
			add_req(req, ch, tgt, per, mode, lv);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults: no switch mapped to any channel
		add_random(200);
		drain();

		// switches 0..6 at the low end of channels 0..6, 7..11 at the high end of channels 0..4
		write_reg(CFG_THRESH, 28'd0);
		write_reg(CFG_MAXINT, 28'd65535);
		write_reg(CFG_ENMASK, 28'hFFF);
		write_reg(CFG_IDLE, 28'd0);
		write_reg(CFG_MINMAP, 28'h6543210);
		write_reg(CFG_MAXMAP, 28'hFFBA987);
		add_req(REQ_TICK, 3'd0, 0, 24'd5, MODE_MOVE, 12'h000);
		add_req(REQ_START, 3'd0, 32'sd3, 24'd1, MODE_MOVE, 12'h000);
		add_req(REQ_START, 3'd1, -32'sd2, 24'hFFFFFF, MODE_MOVE, 12'h000);
		add_req(REQ_START, 3'd2, 32'sh7FFFFFFF, 24'd0, MODE_HMAX, 12'h000);
		add_req(REQ_START, 3'd3, 32'sh80000000, 24'd7, MODE_HMIN, 12'h000);
		add_req(REQ_START, 3'd7, 32'sd9, 24'd4, MODE_MOVE, 12'h000);
		add_req(REQ_START, 3'd4, 32'sd1, 24'd2, MODE_ODD, 12'h000);
		for (int j = 0; j < 4; j++)
			add_req(REQ_TICK, 3'(j), 0, 0, MODE_MOVE, 12'h000);
		add_req(REQ_TICK, 3'd2, 0, 0, MODE_MOVE, 12'hFFF);
		add_req(REQ_TICK, 3'd3, 0, 0, MODE_MOVE, 12'h808);
		add_req(REQ_NOP, 3'd0, 0, 0, MODE_MOVE, 12'h000);
		add_req(REQ_CLEAR, 3'd5, 0, 0, MODE_MOVE, 12'h000);
		// restart a running channel
		add_req(REQ_START, 3'd1, 32'sd5, 24'd3, MODE_MOVE, 12'h000);
		add_req(REQ_TICK, 3'd1, 0, 0, MODE_MOVE, 12'h002);
		add_req(REQ_TICK, 3'd1, 0, 0, MODE_MOVE, 12'h000);
		add_req(REQ_TICK, 3'd7, 0, 0, MODE_MOVE, 12'h000);
		add_random(250);
		drain();

		// high step threshold, tiny interval clamp, inverted switch levels
		write_reg(CFG_THRESH, 28'd65535);
		write_reg(CFG_MAXINT, 28'd1);
		write_reg(CFG_ENMASK, 28'($urandom));
		write_reg(CFG_IDLE, 28'd1);
		write_reg(CFG_MINMAP, 28'($urandom));
		write_reg(CFG_MAXMAP, 28'h0123456);
		add_random(250);
		drain();

		write_reg(CFG_THRESH, 28'd20);
		write_reg(CFG_MAXINT, 28'd150);
		write_reg(CFG_ENMASK, 28'h000);
		write_reg(CFG_IDLE, 28'd0);
		write_reg(CFG_MINMAP, 28'h0000000);
		write_reg(CFG_MAXMAP, 28'h2BA9876);
		add_random(50);
		drain();
		write_reg(CFG_ENMASK, 28'hFFF);
		add_random(200);
		drain();

		if (errors == 0 && expected.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
